[sv/s2i_pkg.sv]
package s2i_pkg;

    localparam int VALUE_W     = 64;
    localparam int BASE_W      = 6;
    localparam int DIGIT_W     = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_BASE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_MIN   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_MAX   = 2'd2;

    // Character codes.
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;
    localparam logic [7:0] CHAR_UPPER_X = 8'h58;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;

    // Radix values.
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 7'd64;
    localparam logic [DIGIT_W-1:0] DIGIT_ZERO = 7'd0;
    localparam logic [DIGIT_W-1:0] DIGIT_HEX_LIMIT = 7'd16;

    // Magnitude limits for positive and negative results.
    localparam logic [VALUE_W-1:0] MAG_LIMIT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] MAG_LIMIT_NEG = 64'h8000_0000_0000_0000;

    // Reset values of the configuration registers.
    localparam logic [BASE_W-1:0]  NUMBER_BASE_RESET = BASE_DEC;
    localparam logic [VALUE_W-1:0] RANGE_MIN_RESET   = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_W-1:0] RANGE_MAX_RESET   = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        DS_NONE = 2'd0,
        DS_SOME = 2'd1,
        DS_OVF  = 2'd2
    } digit_state_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_TOO_SMALL = 2'd2,
        ST_TOO_LARGE = 2'd3
    } status_t;

    // Parse state at the end of a string, handed to the range check.
    typedef struct packed {
        logic                negative;
        logic [VALUE_W-1:0]  magnitude;
        digit_state_t        digit_state;
        logic                all_used;
        logic                too_long;
    } parse_snap_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic                found;
        logic                ovf;
        status_t             status;
        logic [VALUE_W-1:0]  checked;
    } result_t;

    // Value of a digit or letter, DIGIT_NONE for anything else.
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
        logic [DIGIT_W-1:0] d;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = DIGIT_W'(c - CHAR_ZERO);
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            d = DIGIT_W'(c - CHAR_UPPER_A + 8'd10);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            d = DIGIT_W'(c - CHAR_LOWER_A + 8'd10);
        end else begin
            d = DIGIT_NONE;
        end
        return d;
    endfunction

endpackage

[sv/s2i_parse.sv]
module s2i_parse #(
    parameter int MAX_LEN = 256,
    parameter int CNT_W   = 9
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          last,
    input  logic [7:0]                    char_code,
    input  logic [s2i_pkg::BASE_W-1:0]    number_base,
    output s2i_pkg::parse_snap_t          snap,
    output logic [CNT_W-1:0]              end_pos
);

    typedef enum logic [2:0] {
        PH_WS     = 3'd0,
        PH_SIGN   = 3'd1,
        PH_ZERO   = 3'd2,
        PH_XPFX   = 3'd3,
        PH_DIGITS = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);
    localparam int MAC_W = s2i_pkg::VALUE_W + s2i_pkg::BASE_W;

    phase_t                              phase_reg, phase_next;
    logic                                neg_reg, neg_next;
    logic [s2i_pkg::BASE_W-1:0]          base_reg, base_next;
    logic [s2i_pkg::VALUE_W-1:0]         acc_reg, acc_next;
    s2i_pkg::digit_state_t               ds_reg, ds_next;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic [CNT_W-1:0]                    end_reg, end_next;
    logic                                tl_reg, tl_next;

    logic [s2i_pkg::DIGIT_W-1:0]         digit;
    logic                                is_space;
    logic                                is_sign;
    logic                                is_x;
    logic                                start_num;
    logic                                zero_pfx;
    logic                                do_accept;
    logic                                accept_ok;
    logic [s2i_pkg::BASE_W-1:0]          acc_base;
    logic [s2i_pkg::DIGIT_W-1:0]         acc_digit;
    logic [s2i_pkg::VALUE_W-1:0]         limit;
    logic [MAC_W-1:0]                    mac;
    logic                                mac_ovf;

    assign digit    = s2i_pkg::digit_of(char_code);
    assign is_space = (char_code == s2i_pkg::CHAR_SPACE) ||
                      (char_code >= s2i_pkg::CHAR_TAB && char_code <= s2i_pkg::CHAR_CR);
    assign is_sign  = (char_code == s2i_pkg::CHAR_MINUS) || (char_code == s2i_pkg::CHAR_PLUS);
    assign is_x     = (char_code == s2i_pkg::CHAR_LOWER_X) ||
                      (char_code == s2i_pkg::CHAR_UPPER_X);
    assign zero_pfx = (char_code == s2i_pkg::CHAR_ZERO) &&
                      ((number_base == s2i_pkg::BASE_AUTO) || (number_base == s2i_pkg::BASE_HEX));

    // Pick the radix and digit that go into the multiply-add for this character.
    always_comb
    begin
        start_num = ((phase_reg == PH_WS) && !is_space && !is_sign) || (phase_reg == PH_SIGN);
        acc_digit = digit;
        acc_base  = base_reg;
        if (start_num) begin
            if (zero_pfx) begin
                acc_digit = s2i_pkg::DIGIT_ZERO;
                acc_base  = (number_base == s2i_pkg::BASE_AUTO) ? s2i_pkg::BASE_OCT
                                                                 : s2i_pkg::BASE_HEX;
            end else begin
                acc_base  = (number_base == s2i_pkg::BASE_AUTO) ? s2i_pkg::BASE_DEC
                                                                 : number_base;
            end
        end
        do_accept = start_num ||
                    ((phase_reg == PH_ZERO) && !is_x) ||
                    ((phase_reg == PH_XPFX) && (digit < s2i_pkg::DIGIT_HEX_LIMIT)) ||
                    (phase_reg == PH_DIGITS);
        accept_ok = do_accept && (acc_base != s2i_pkg::BASE_AUTO) &&
                    (acc_digit < {1'b0, acc_base});
    end

    // The overflow test compares acc * base + digit against the limit directly.
    assign limit   = neg_reg ? s2i_pkg::MAG_LIMIT_NEG : s2i_pkg::MAG_LIMIT_POS;
    assign mac     = MAC_W'(acc_reg) * MAC_W'(acc_base) + MAC_W'(acc_digit);
    assign mac_ovf = mac > MAC_W'(limit);

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        ds_next    = ds_reg;
        cnt_next   = cnt_reg;
        end_next   = end_reg;
        tl_next    = tl_reg;
        if (cnt_reg >= MAX_CNT) begin
            tl_next = 1'b1;
        end else begin
            cnt_next = cnt_reg + 1'b1;
            case (phase_reg)
                PH_WS:
                begin
                    if (char_code == s2i_pkg::CHAR_MINUS) begin
                        neg_next   = 1'b1;
                        phase_next = PH_SIGN;
                    end else if (char_code == s2i_pkg::CHAR_PLUS) begin
                        phase_next = PH_SIGN;
                    end
                end
                PH_ZERO:
                begin
                    if (is_x) begin
                        base_next  = s2i_pkg::BASE_HEX;
                        phase_next = PH_XPFX;
                    end else begin
                        phase_next = PH_DIGITS;
                    end
                end
                PH_XPFX:
                begin
                    phase_next = (digit < s2i_pkg::DIGIT_HEX_LIMIT) ? PH_DIGITS : PH_DONE;
                end
                default:
                begin
                end
            endcase
            if (start_num) begin
                base_next  = acc_base;
                phase_next = zero_pfx ? PH_ZERO : PH_DIGITS;
            end
            if (do_accept) begin
                if (!accept_ok) begin
                    phase_next = PH_DONE;
                end else begin
                    end_next = cnt_next;
                    if (ds_reg != s2i_pkg::DS_OVF) begin
                        if (mac_ovf) begin
                            acc_next = limit;
                            ds_next  = s2i_pkg::DS_OVF;
                        end else begin
                            acc_next = mac[s2i_pkg::VALUE_W-1:0];
                            ds_next  = s2i_pkg::DS_SOME;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_WS;
            neg_reg   <= 1'b0;
            base_reg  <= s2i_pkg::BASE_AUTO;
            acc_reg   <= '0;
            ds_reg    <= s2i_pkg::DS_NONE;
            cnt_reg   <= '0;
            end_reg   <= '0;
            tl_reg    <= 1'b0;
        end else if (step) begin
            if (last) begin
                phase_reg <= PH_WS;
                neg_reg   <= 1'b0;
                base_reg  <= s2i_pkg::BASE_AUTO;
                acc_reg   <= '0;
                ds_reg    <= s2i_pkg::DS_NONE;
                cnt_reg   <= '0;
                end_reg   <= '0;
                tl_reg    <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                base_reg  <= base_next;
                acc_reg   <= acc_next;
                ds_reg    <= ds_next;
                cnt_reg   <= cnt_next;
                end_reg   <= end_next;
                tl_reg    <= tl_next;
            end
        end
    end

    assign snap.negative    = neg_next;
    assign snap.magnitude   = acc_next;
    assign snap.digit_state = ds_next;
    assign snap.all_used    = (end_next == cnt_next);
    assign snap.too_long    = tl_next;
    assign end_pos          = end_next;

endmodule

[sv/s2i_check.sv]
module s2i_check #(
    parameter int CNT_W = 9
) (
    input  s2i_pkg::parse_snap_t           snap,
    input  logic [CNT_W-1:0]               end_pos,
    input  logic [s2i_pkg::VALUE_W-1:0]    range_min,
    input  logic [s2i_pkg::VALUE_W-1:0]    range_max,
    input  logic                           range_bad,
    output s2i_pkg::result_t               res,
    output logic [CNT_W-1:0]               end_position
);

    logic [s2i_pkg::VALUE_W-1:0] value;
    logic                        found;
    logic                        ovf;
    s2i_pkg::status_t            status;

    assign value = snap.negative ? (s2i_pkg::VALUE_W'(0) - snap.magnitude) : snap.magnitude;
    assign found = (snap.digit_state != s2i_pkg::DS_NONE);
    assign ovf   = (snap.digit_state == s2i_pkg::DS_OVF);

    // An overflowed value is out of range whatever the limits say, unless the string or the range is invalid.
    always_comb
    begin
        if (range_bad) begin
            status = s2i_pkg::ST_INVALID;
        end else if (!found || !snap.all_used || snap.too_long) begin
            status = s2i_pkg::ST_INVALID;
        end else if ((ovf && snap.negative) || ($signed(value) < $signed(range_min))) begin
            status = s2i_pkg::ST_TOO_SMALL;
        end else if ((ovf && !snap.negative) || ($signed(value) > $signed(range_max))) begin
            status = s2i_pkg::ST_TOO_LARGE;
        end else begin
            status = s2i_pkg::ST_OK;
        end
    end

    assign res.value   = value;
    assign res.found   = found;
    assign res.ovf     = ovf;
    assign res.status  = status;
    assign res.checked = (status == s2i_pkg::ST_OK) ? value : '0;
    assign end_position = found ? end_pos : '0;

endmodule

[sv/string_to_integer_range_check.sv]
// String to integer parser with range check.
// Characters arrive one per transfer on the char channel (char_code, with
// last_char marking the final byte of a string). After the final byte the
// block sends one result transfer on the result channel: the parsed and
// saturated value, digit and overflow flags, the end position of the number,
// a range status and the checked value (zero unless the status is ok).
// Leading whitespace and one sign are skipped; in automatic or hex radix a
// 0x prefix is taken, and in automatic radix a leading 0 selects octal.
// Throughput is one character per cycle while char_ready is high: each
// character passes an input register, then one multiply-add by the radix
// with its overflow compare updates the parse state. A finished string's
// state is registered, then its result in the output register. Configuration
// is written through cfg_write_en, cfg_index and cfg_data, by the user only
// while the block is idle; the block does not enforce this. Reset clears the
// parse state and empties the pipeline, and the configuration returns to
// radix 10 and the full signed 64-bit range. When the receiver stalls, the
// result waits in the output register while the block keeps taking
// characters. A second finished string can wait behind it; once the last
// character of a third string sits in the input register, char_ready drops.
module string_to_integer_range_check #(
    parameter int MAX_LEN = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [s2i_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [s2i_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  char_valid,
    output logic                                  char_ready,
    input  logic [7:0]                            char_code,
    input  logic                                  last_char,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [s2i_pkg::VALUE_W-1:0]    parsed_value,
    output logic                                  digits_found,
    output logic                                  overflowed,
    output logic [$clog2(MAX_LEN+1)-1:0]          end_position,
    output logic [1:0]                            status,
    output logic signed [s2i_pkg::VALUE_W-1:0]    checked_value
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    // Configuration registers.
    logic [s2i_pkg::BASE_W-1:0]     number_base_reg;
    logic [s2i_pkg::VALUE_W-1:0]    range_min_reg;
    logic [s2i_pkg::VALUE_W-1:0]    range_max_reg;
    logic                           range_bad_reg;

    // Input register.
    logic                           s0_valid_reg;
    logic [7:0]                     s0_char_reg;
    logic                           s0_last_reg;

    // Finished parse state of one string.
    logic                           fin_valid_reg;
    s2i_pkg::parse_snap_t           fin_snap_reg;
    logic [CNT_W-1:0]               fin_end_reg;

    // Output register.
    logic                           out_valid_reg;
    s2i_pkg::result_t               out_res_reg;
    logic [CNT_W-1:0]               out_end_reg;

    logic                           out_free;
    logic                           fin_free;
    logic                           s0_step;
    s2i_pkg::parse_snap_t           snap;
    logic [CNT_W-1:0]               snap_end;
    s2i_pkg::result_t               res;
    logic [CNT_W-1:0]               res_end;

    // A stage may take new data when it is empty or its content leaves this cycle.
    // A character that is not the last one only updates the parse state.
    assign out_free   = !out_valid_reg || result_ready;
    assign fin_free   = !fin_valid_reg || out_free;
    assign s0_step    = s0_valid_reg && (!s0_last_reg || fin_free);
    assign char_ready = !s0_valid_reg || s0_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            number_base_reg <= s2i_pkg::NUMBER_BASE_RESET;
            range_min_reg   <= s2i_pkg::RANGE_MIN_RESET;
            range_max_reg   <= s2i_pkg::RANGE_MAX_RESET;
            range_bad_reg   <= 1'b0;
        end else begin
            if (cfg_write_en) begin
                case (cfg_index)
                    s2i_pkg::CFG_NUMBER_BASE: number_base_reg <= cfg_data[s2i_pkg::BASE_W-1:0];
                    s2i_pkg::CFG_RANGE_MIN:   range_min_reg   <= cfg_data;
                    s2i_pkg::CFG_RANGE_MAX:   range_max_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            // The range order is registered, compared from the stored limits.
            range_bad_reg <= $signed(range_min_reg) > $signed(range_max_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s0_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (char_ready) begin
                s0_valid_reg <= char_valid;
            end
            if (fin_free) begin
                fin_valid_reg <= s0_step && s0_last_reg;
            end
            if (out_free) begin
                out_valid_reg <= fin_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid) begin
            s0_char_reg <= char_code;
            s0_last_reg <= last_char;
        end
        if (s0_step && s0_last_reg) begin
            fin_snap_reg <= snap;
            fin_end_reg  <= snap_end;
        end
        if (out_free && fin_valid_reg) begin
            out_res_reg <= res;
            out_end_reg <= res_end;
        end
    end

    s2i_parse #(
        .MAX_LEN (MAX_LEN),
        .CNT_W   (CNT_W)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s0_step),
        .last        (s0_last_reg),
        .char_code   (s0_char_reg),
        .number_base (number_base_reg),
        .snap        (snap),
        .end_pos     (snap_end)
    );

    s2i_check #(
        .CNT_W (CNT_W)
    ) u_check (
        .snap         (fin_snap_reg),
        .end_pos      (fin_end_reg),
        .range_min    (range_min_reg),
        .range_max    (range_max_reg),
        .range_bad    (range_bad_reg),
        .res          (res),
        .end_position (res_end)
    );

    assign result_valid  = out_valid_reg;
    assign parsed_value  = out_res_reg.value;
    assign digits_found  = out_res_reg.found;
    assign overflowed    = out_res_reg.ovf;
    assign end_position  = out_end_reg;
    assign status        = out_res_reg.status;
    assign checked_value = out_res_reg.checked;

`ifndef SYNTH
    // An ok result always carries digits and passes its value through.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == s2i_pkg::ST_OK)) |->
            (digits_found && (checked_value == parsed_value)))
        else $error("ok result without digits or with altered value");

    // An overflowed value never passes the range check.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && overflowed) |-> (digits_found && (status != s2i_pkg::ST_OK)))
        else $error("overflowed result reported as ok");

    // The end position is nonzero exactly when digits were found.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (digits_found == (end_position != '0)))
        else $error("end position disagrees with digit flag");

    // Input backpressure only arises from a held character.
    assert property (@(posedge clk) disable iff (!rst_n)
        !char_ready |-> (s0_valid_reg && s0_last_reg && fin_valid_reg && out_valid_reg))
        else $error("char_ready low with room in the pipeline");
`endif

endmodule
